// ----- sv/lrmm_pkg.sv -----
// shared types and constants for the legged robot mode manager
package lrmm_pkg;

    // operating modes of the robot
    typedef enum logic [2:0] {
        MODE_INIT       = 3'd0,
        MODE_CALIB      = 3'd1,
        MODE_SLEEP      = 3'd2,
        MODE_STAND      = 3'd3,
        MODE_WALK       = 3'd4,
        MODE_GYRO       = 3'd5,
        MODE_GYRO_FIXED = 3'd6
    } t_mode;

    // packet kinds carried with each tick
    localparam logic [1:0] PKT_CONTROL  = 2'd0;
    localparam logic [1:0] PKT_SETTINGS = 2'd1;

    // calibration byte codes
    localparam logic [7:0] CALIB_ENTER = 8'd1;
    localparam logic [7:0] CALIB_LEAVE = 8'd0;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_STAND_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 2'd2;

    localparam logic [31:0] RST_STAND_DELAY = 32'd2000;
    localparam logic [31:0] RST_SLEEP_DELAY = 32'd10000;
    localparam logic [6:0]  RST_DEADZONE    = 7'd10;

    // stick remap x*200/254 = floor(x*100/127) via (x*100*16513 + 200) >> 21
    localparam int unsigned STICK_PROD_W = 29;
    localparam int unsigned STICK_SHIFT  = 21;
    localparam logic [20:0] STICK_RECIP  = 21'd1651300;
    localparam logic [STICK_PROD_W-1:0] STICK_BIAS = 29'd200;
    localparam logic [7:0]  STICK_CENTER = 8'd100;

    // decision handed from the decision logic to the state registers
    typedef struct packed {
        t_mode request;
        logic  touch;
    } t_decision;

endpackage

// ----- sv/lrmm_stick.sv -----
// joystick remap and deadzone test for one stick axis
module lrmm_stick (
    input  logic [7:0] i_raw,
    input  logic [6:0] i_deadzone,
    output logic       o_moved
);
    import lrmm_pkg::*;

    logic [STICK_PROD_W-1:0] prod;
    logic [7:0]              scaled;
    logic [7:0]              mag;

    // scaled value 0..200, magnitude around the center
    always_comb begin
        prod    = STICK_PROD_W'(i_raw) * STICK_PROD_W'(STICK_RECIP) + STICK_BIAS;
        scaled  = prod[STICK_SHIFT +: 8];
        mag     = (scaled >= STICK_CENTER) ? (scaled - STICK_CENTER)
                                           : (STICK_CENTER - scaled);
        o_moved = mag > {1'b0, i_deadzone};
    end

endmodule

// ----- sv/lrmm_decide.sv -----
// next requested mode decision for one tick
module lrmm_decide (
    input  lrmm_pkg::t_mode     i_request,
    input  logic                i_link_up,
    input  logic [1:0]          i_packet_kind,
    input  logic                i_moved,
    input  logic                i_bumper_a,
    input  logic                i_bumper_c,
    input  logic [7:0]          i_calib_flag,
    input  logic [31:0]         i_now_ms,
    input  logic [31:0]         i_last_move_ms,
    input  logic [31:0]         i_stand_delay,
    input  logic [31:0]         i_sleep_delay,
    output lrmm_pkg::t_decision o_decision
);
    import lrmm_pkg::*;

    logic [31:0] idle;
    logic        ge_stand;
    logic        ge_sleep;
    t_mode       req;

    always_comb begin
        idle     = i_now_ms - i_last_move_ms;
        ge_stand = idle >= i_stand_delay;
        ge_sleep = idle >= i_sleep_delay;
        req      = i_request;
        o_decision.touch = 1'b0;

        priority if (!i_link_up) begin
            req = MODE_SLEEP;
        end else if (i_packet_kind == PKT_CONTROL) begin
            // bumpers first, then sticks, then idle timeouts
            priority if (i_bumper_a) begin
                o_decision.touch = 1'b1;
                if (req != MODE_GYRO)
                    req = (req != MODE_STAND) ? MODE_STAND : MODE_GYRO;
            end else if (i_bumper_c) begin
                o_decision.touch = 1'b1;
                if (req != MODE_GYRO_FIXED)
                    req = (req != MODE_STAND) ? MODE_STAND : MODE_GYRO_FIXED;
            end else if (i_moved) begin
                o_decision.touch = 1'b1;
                req = (req == MODE_SLEEP) ? MODE_STAND : MODE_WALK;
            end else begin
                if (req != MODE_SLEEP && ge_stand && !ge_sleep)
                    req = MODE_STAND;
                else if (ge_sleep && req != MODE_SLEEP)
                    req = MODE_SLEEP;
            end
        end else if (i_packet_kind == PKT_SETTINGS) begin
            // calibration switching
            if (req != MODE_CALIB && req != MODE_SLEEP)
                req = MODE_SLEEP;
            if (i_calib_flag == CALIB_ENTER)
                req = MODE_CALIB;
            if (req == MODE_CALIB && i_calib_flag == CALIB_LEAVE)
                req = MODE_SLEEP;
        end else begin
            // other packet kinds leave the request as it is
            req = i_request;
        end

        o_decision.request = req;
    end

endmodule

// ----- sv/legged_robot_mode_manager.sv -----
// top level of the legged robot mode manager: registers, handshakes, state
//
//  channel   direction  handshake            payload
//  tick      in         i_valid / o_ready    i_link_up .. i_now_ms
//  result    out        o_valid / i_ready    o_run_mode, o_mode_entered, o_left_mode, o_next_mode
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one tick per cycle sustained while i_ready is high; a tick passes the input register, then the result register
// a tick is registered, then decided combinationally from the mode and idle-time state
// the result register holds under stall while the input register takes one more tick
// synchronous active-low reset: init mode, sleep requested, last move time zero
module legged_robot_mode_manager (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lrmm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lrmm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_link_up,
    input  logic [1:0]                          i_packet_kind,
    input  logic [7:0]                          i_joy_left_x,
    input  logic [7:0]                          i_joy_left_y,
    input  logic [7:0]                          i_joy_right_x,
    input  logic [7:0]                          i_joy_right_y,
    input  logic                                i_bumper_a_down,
    input  logic                                i_bumper_c_down,
    input  logic [7:0]                          i_calib_flag,
    input  logic [31:0]                         i_now_ms,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2:0]                          o_run_mode,
    output logic                                o_mode_entered,
    output logic [2:0]                          o_left_mode,
    output logic [2:0]                          o_next_mode
);
    import lrmm_pkg::*;

    // configuration registers
    logic [31:0] r_stand_delay;
    logic [31:0] r_sleep_delay;
    logic [6:0]  r_deadzone;

    // input register
    logic        r_in_valid;
    logic        r_in_link;
    logic [1:0]  r_in_kind;
    logic [7:0]  r_in_lx;
    logic [7:0]  r_in_ly;
    logic [7:0]  r_in_rx;
    logic [7:0]  r_in_ry;
    logic        r_in_ba;
    logic        r_in_bc;
    logic [7:0]  r_in_calib;
    logic [31:0] r_in_now;

    // mode state
    t_mode       r_active;
    t_mode       r_request;
    logic [31:0] r_last_move;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_out_run;
    logic        r_out_entered;
    logic [2:0]  r_out_left;
    logic [2:0]  r_out_next;

    logic [3:0]  moved;
    logic        advance;
    logic        entered;
    t_decision   decision;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign entered = r_request != r_active;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stand_delay <= RST_STAND_DELAY;
            r_sleep_delay <= RST_SLEEP_DELAY;
            r_deadzone    <= RST_DEADZONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STAND_DELAY: r_stand_delay <= i_cfg_data[31:0];
                CFG_SLEEP_DELAY: r_sleep_delay <= i_cfg_data[31:0];
                CFG_DEADZONE:    r_deadzone    <= i_cfg_data[6:0];
                default:         ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_link  <= i_link_up;
            r_in_kind  <= i_packet_kind;
            r_in_lx    <= i_joy_left_x;
            r_in_ly    <= i_joy_left_y;
            r_in_rx    <= i_joy_right_x;
            r_in_ry    <= i_joy_right_y;
            r_in_ba    <= i_bumper_a_down;
            r_in_bc    <= i_bumper_c_down;
            r_in_calib <= i_calib_flag;
            r_in_now   <= i_now_ms;
        end
    end

    // stick tests
    lrmm_stick u_stick_lx (.i_raw(r_in_lx), .i_deadzone(r_deadzone), .o_moved(moved[0]));
    lrmm_stick u_stick_ly (.i_raw(r_in_ly), .i_deadzone(r_deadzone), .o_moved(moved[1]));
    lrmm_stick u_stick_rx (.i_raw(r_in_rx), .i_deadzone(r_deadzone), .o_moved(moved[2]));
    lrmm_stick u_stick_ry (.i_raw(r_in_ry), .i_deadzone(r_deadzone), .o_moved(moved[3]));

    // mode decision
    lrmm_decide u_decide (
        .i_request      (r_request),
        .i_link_up      (r_in_link),
        .i_packet_kind  (r_in_kind),
        .i_moved        (|moved),
        .i_bumper_a     (r_in_ba),
        .i_bumper_c     (r_in_bc),
        .i_calib_flag   (r_in_calib),
        .i_now_ms       (r_in_now),
        .i_last_move_ms (r_last_move),
        .i_stand_delay  (r_stand_delay),
        .i_sleep_delay  (r_sleep_delay),
        .o_decision     (decision)
    );

    // mode state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= MODE_INIT;
            r_request   <= MODE_SLEEP;
            r_last_move <= '0;
        end else if (advance) begin
            r_active  <= r_request;
            r_request <= decision.request;
            if (decision.touch)
                r_last_move <= r_in_now;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_run     <= r_request;
            r_out_entered <= entered;
            r_out_left    <= entered ? r_active : MODE_INIT;
            r_out_next    <= decision.request;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_run_mode     = r_out_run;
    assign o_mode_entered = r_out_entered;
    assign o_left_mode    = r_out_left;
    assign o_next_mode    = r_out_next;

    // no exit reported without an entry
    a_left_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_mode_entered |-> o_left_mode == MODE_INIT)
        else $error("left mode reported without a mode entry");

    // an entry always leaves a different mode
    a_left_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mode_entered |-> o_left_mode != o_run_mode)
        else $error("entered mode equals left mode");

    // link loss forces a sleep request
    a_link_sleep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_link |=> r_request == MODE_SLEEP)
        else $error("sleep not requested after link loss");

    // mode state moves only with a transaction
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_active) && $stable(r_request) && $stable(r_last_move))
        else $error("mode state changed without a tick");

    // result register holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_mode))
        else $error("result dropped under stall");

endmodule
